/* hdl/linear_interp_resampler_gain_macros.svh */
// Assertion macros shared by the checker of the resampler.
`ifndef LINEAR_INTERP_RESAMPLER_GAIN_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_GAIN_MACROS_SVH

// Checked only while the block is out of reset.
`define LIRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define LIRG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/lirg_pkg.sv */
// Types, constants and codes shared by the resampler modules.
package lirg_pkg;

  localparam int CHANNELS_DEF  = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_OUT_DEF   = 8;

  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 28;
  localparam int STEP_W    = 20;
  localparam int COUNT_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int POS_W     = 40;
  localparam int FRAMES_W  = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_RST = 16'd2;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd4096;

  // Depth of the result queue and latency of one lane.
  localparam int FIFO_DEPTH = 8;
  localparam int LANE_LAT   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP  = 2'd0,
    CFG_COUNT = 2'd1,
    CFG_GAIN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic vld;
    logic last;
  } issue_t;

endpackage

/* hdl/lirg_lane.sv */
// One channel lane: interpolation, gain, rounding and saturation in three stages.
module lirg_lane #(
  parameter int FRAC_BITS = lirg_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic signed [lirg_pkg::SAMPLE_W-1:0] a,
  input  logic signed [lirg_pkg::SAMPLE_W-1:0] b,
  input  logic        [FRAC_BITS-1:0]          k,
  input  logic        [lirg_pkg::GAIN_W-1:0]   gain,
  output logic signed [lirg_pkg::OUT_W-1:0]    res
);

  localparam int PROD1_W = FRAC_BITS + 18;
  localparam int X_W     = FRAC_BITS + 19;
  localparam int PROD2_W = FRAC_BITS + 36;
  localparam int Q_W     = PROD2_W - (FRAC_BITS + 4);
  localparam int OW      = lirg_pkg::OUT_W;

  localparam logic [PROD2_W-1:0] RND = PROD2_W'(1) << (FRAC_BITS + 3);

  logic signed [lirg_pkg::SAMPLE_W:0] diff;
  logic signed [PROD1_W-1:0]          prod1;
  logic signed [PROD1_W-1:0]          prod1_r;
  logic signed [lirg_pkg::SAMPLE_W-1:0] a_r;
  logic signed [X_W-1:0]              x;
  logic signed [PROD2_W-1:0]          prod2;
  logic signed [PROD2_W-1:0]          prod2_r;
  logic signed [PROD2_W-1:0]          rounded;
  logic signed [Q_W-1:0]              q;
  logic signed [OW-1:0]               sat;
  logic signed [OW-1:0]               res_r;

  assign diff  = $signed({b[lirg_pkg::SAMPLE_W-1], b}) - $signed({a[lirg_pkg::SAMPLE_W-1], a});
  assign prod1 = diff * $signed({1'b0, k});

  always_ff @(posedge clk) begin
    prod1_r <= prod1;
    a_r     <= a;
  end

  assign x = $signed({{3{a_r[lirg_pkg::SAMPLE_W-1]}}, a_r, {FRAC_BITS{1'b0}}})
           + $signed({prod1_r[PROD1_W-1], prod1_r});
  assign prod2 = x * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    prod2_r <= prod2;
  end

  // Adding half an output step and shifting arithmetically rounds half up.
  assign rounded = prod2_r + $signed(RND);
  assign q       = rounded[PROD2_W-1:FRAC_BITS+4];

  always_comb begin
    if (q[Q_W-1:OW-1] == '0 || q[Q_W-1:OW-1] == '1) begin
      sat = q[OW-1:0];
    end else if (q[Q_W-1]) begin
      sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= sat;
  end

  assign res = res_r;

endmodule

/* hdl/lirg_ctrl.sv */
// Sequencer: configuration registers, frame state and the issue of outputs to the lanes.
module lirg_ctrl #(
  parameter int CHANNELS          = lirg_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS         = lirg_pkg::FRAC_BITS_DEF,
  parameter int MAX_OUT_PER_FRAME = lirg_pkg::MAX_OUT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wen,
  input  logic [lirg_pkg::CFG_IDX_W-1:0]                cfg_addr,
  input  logic [lirg_pkg::CFG_W-1:0]                    cfg_wdata,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [CHANNELS-1:0][lirg_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                          in_end,
  input  logic                                          issue_ok,
  output lirg_pkg::issue_t                              issue,
  output logic [CHANNELS-1:0][lirg_pkg::SAMPLE_W-1:0]   lane_a,
  output logic [CHANNELS-1:0][lirg_pkg::SAMPLE_W-1:0]   lane_b,
  output logic [FRAC_BITS-1:0]                          lane_k,
  output logic [lirg_pkg::GAIN_W-1:0]                   gain
);

  localparam int NW    = $clog2(MAX_OUT_PER_FRAME + 1);
  localparam int POS_W = lirg_pkg::POS_W;
  localparam int INT_W = POS_W - FRAC_BITS;
  localparam int CW    = lirg_pkg::COUNT_W;

  localparam logic [lirg_pkg::STEP_W-1:0] STEP_RST = lirg_pkg::STEP_W'(64'd1 << FRAC_BITS);

  logic [lirg_pkg::STEP_W-1:0]  step_r;
  logic [CW-1:0]                count_r;
  logic [lirg_pkg::GAIN_W-1:0]  gain_r;

  lirg_pkg::state_t state_r, state_nxt;
  logic [CHANNELS-1:0][lirg_pkg::SAMPLE_W-1:0] cur_r, cur_nxt;
  logic [CHANNELS-1:0][lirg_pkg::SAMPLE_W-1:0] held_r, held_nxt;
  logic                           end_r, end_nxt;
  logic                           have_held_r, have_held_nxt;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]                  done_r, done_nxt;
  logic [lirg_pkg::FRAMES_W-1:0]  frames_r, frames_nxt;
  logic [NW-1:0]                  n_r, n_nxt;

  logic [CW:0]   done_inc;
  logic [NW:0]   n_inc;
  logic          is_final;
  logic          cap_hit;
  logic          room;
  logic          due_interp;
  logic [POS_W-1:0] pos_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RST;
      count_r <= lirg_pkg::COUNT_RST;
      gain_r  <= lirg_pkg::GAIN_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        lirg_pkg::CFG_STEP:  step_r  <= cfg_wdata[lirg_pkg::STEP_W-1:0];
        lirg_pkg::CFG_COUNT: count_r <= cfg_wdata[CW-1:0];
        lirg_pkg::CFG_GAIN:  gain_r  <= cfg_wdata[lirg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lirg_pkg::ST_IDLE;
      have_held_r <= 1'b0;
      pos_r       <= '0;
      done_r      <= '0;
      frames_r    <= '0;
      n_r         <= '0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      have_held_r <= have_held_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      frames_r    <= frames_nxt;
      n_r         <= n_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    end_r <= end_nxt;
  end

  assign done_inc   = {1'b0, done_r} + 1'b1;
  assign n_inc      = {1'b0, n_r} + 1'b1;
  assign is_final   = (done_inc == {1'b0, count_r});
  assign cap_hit    = (n_inc == (NW + 1)'(MAX_OUT_PER_FRAME));
  assign room       = (n_r < NW'(MAX_OUT_PER_FRAME));
  assign pos_adv    = pos_r + POS_W'(step_r);
  assign due_interp = have_held_r && (done_r < count_r) &&
                      (pos_r[POS_W-1:FRAC_BITS] < INT_W'(frames_r));

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    held_nxt      = held_r;
    have_held_nxt = have_held_r;
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    frames_nxt    = frames_r;
    n_nxt         = n_r;
    in_tready     = 1'b0;
    issue         = '0;
    case (state_r)
      lirg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cur_nxt   = in_sample;
          end_nxt   = in_end;
          n_nxt     = '0;
          state_nxt = lirg_pkg::ST_INTERP;
        end
      end
      lirg_pkg::ST_INTERP: begin
        if (due_interp) begin
          if (room) begin
            if (issue_ok) begin
              // On a closing frame the request that fills the per-frame cap is the last one.
              issue.vld  = 1'b1;
              issue.last = is_final || (end_r && cap_hit);
              n_nxt      = n_inc[NW-1:0];
              pos_nxt    = pos_adv;
              done_nxt   = done_inc[CW-1:0];
            end
          end else begin
            // Past the cap the output is dropped but still counted.
            pos_nxt  = pos_adv;
            done_nxt = done_inc[CW-1:0];
          end
        end else if (end_r) begin
          state_nxt = lirg_pkg::ST_FLUSH;
        end else begin
          held_nxt      = cur_r;
          have_held_nxt = 1'b1;
          if (frames_r != '1) begin
            frames_nxt = frames_r + 1'b1;
          end
          state_nxt = lirg_pkg::ST_IDLE;
        end
      end
      lirg_pkg::ST_FLUSH: begin
        if ((done_r < count_r) && room) begin
          if (issue_ok) begin
            issue.vld  = 1'b1;
            issue.last = is_final || cap_hit;
            n_nxt      = n_inc[NW-1:0];
            done_nxt   = done_inc[CW-1:0];
          end
        end else begin
          have_held_nxt = 1'b0;
          pos_nxt       = '0;
          done_nxt      = '0;
          frames_nxt    = '0;
          state_nxt     = lirg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lirg_pkg::ST_IDLE;
      end
    endcase
  end

  // The tail of a closing frame is the frame itself with zero weight.
  assign lane_a = (state_r == lirg_pkg::ST_FLUSH) ? cur_r : held_r;
  assign lane_b = cur_r;
  assign lane_k = (state_r == lirg_pkg::ST_FLUSH) ? '0 : pos_r[FRAC_BITS-1:0];
  assign gain   = gain_r;

endmodule

/* hdl/lirg_merge.sv */
// Merging stage: aligns the lane results with their flags and queues them for the output.
module lirg_merge #(
  parameter int CHANNELS = lirg_pkg::CHANNELS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  lirg_pkg::issue_t                           issue,
  output logic                                       issue_ok,
  input  logic [CHANNELS-1:0][lirg_pkg::OUT_W-1:0]   lane_res,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((CHANNELS*lirg_pkg::OUT_W+7)/8)*8-1:0] out_tdata,
  output logic                                       out_tlast
);

  localparam int DEPTH   = lirg_pkg::FIFO_DEPTH;
  localparam int LAT     = lirg_pkg::LANE_LAT;
  localparam int DATA_W  = CHANNELS * lirg_pkg::OUT_W;
  localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int ENTRY_W = DATA_W + 1;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W   = $clog2(DEPTH + LAT + 1);

  lirg_pkg::issue_t [LAT-1:0] pipe_r;
  logic [ENTRY_W-1:0]         mem_r [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r;
  logic [PTR_W-1:0]           rd_ptr_r;
  logic [CNT_W-1:0]           count_r;
  logic [OCC_W-1:0]           occ;
  logic                       push;
  logic                       pop;
  logic [ENTRY_W-1:0]         head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r <= '0;
    end else begin
      pipe_r <= {pipe_r[LAT-2:0], issue};
    end
  end

  // Requests still in the lanes hold a place in the queue already.
  always_comb begin
    occ = OCC_W'(count_r);
    for (int i = 0; i < LAT; i++) begin
      occ = occ + OCC_W'(pipe_r[i].vld);
    end
  end

  assign issue_ok = (occ < OCC_W'(DEPTH));
  assign push     = pipe_r[LAT-1].vld;
  assign pop      = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {pipe_r[LAT-1].last, lane_res};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = TDATA_W'(head[DATA_W-1:0]);
  assign out_tlast  = head[DATA_W];

endmodule

/* hdl/linear_interp_resampler_gain.sv */
// Stereo linear interpolation resampler with gain: top level joining sequencer, lanes and queue.
//
// Frames of a block arrive one per request, the last marked by in_tlast. The sequencer steps
// through every output due at a frame, including outputs that fall beyond the per-frame
// limit and are dropped; a closing frame also issues the tail of the block within that
// limit. The sequencer issues at most one output a cycle to one lane per channel, and a
// very small or zero step can make a single frame yield up to output_count outputs. Results
// pass through the lane registers into an eight-entry queue; when the queued results and
// those still in the lanes fill the queue the sequencer waits, and it takes no new frame
// until it is done with the current one. Configuration writes take effect on the next
// cycle and belong between blocks.
module linear_interp_resampler_gain #(
  parameter int CHANNELS          = lirg_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS         = lirg_pkg::FRAC_BITS_DEF,
  parameter int MAX_OUT_PER_FRAME = lirg_pkg::MAX_OUT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wen,
  input  logic [lirg_pkg::CFG_IDX_W-1:0]                cfg_addr,
  input  logic [lirg_pkg::CFG_W-1:0]                    cfg_wdata,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // sample_left [15:0], sample_right [31:16], further channels above
  input  logic [CHANNELS*lirg_pkg::SAMPLE_W-1:0]        in_tdata,
  // block_end
  input  logic                                          in_tlast,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // out_left [27:0], out_right [55:28], further channels above, zero padded to bytes
  output logic [((CHANNELS*lirg_pkg::OUT_W+7)/8)*8-1:0] out_tdata,
  // out_last
  output logic                                          out_tlast
);

  localparam int SW = lirg_pkg::SAMPLE_W;

  logic [CHANNELS-1:0][SW-1:0]              in_sample;
  logic [CHANNELS-1:0][SW-1:0]              lane_a;
  logic [CHANNELS-1:0][SW-1:0]              lane_b;
  logic [FRAC_BITS-1:0]                     lane_k;
  logic [lirg_pkg::GAIN_W-1:0]              gain;
  logic [CHANNELS-1:0][lirg_pkg::OUT_W-1:0] lane_res;
  lirg_pkg::issue_t                         issue;
  logic                                     issue_ok;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    assign in_sample[c] = in_tdata[c*SW +: SW];

    lirg_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .a    ($signed(lane_a[c])),
      .b    ($signed(lane_b[c])),
      .k    (lane_k),
      .gain (gain),
      .res  (lane_res[c])
    );
  end

  lirg_ctrl #(
    .CHANNELS          (CHANNELS),
    .FRAC_BITS         (FRAC_BITS),
    .MAX_OUT_PER_FRAME (MAX_OUT_PER_FRAME)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_sample),
    .in_end    (in_tlast),
    .issue_ok  (issue_ok),
    .issue     (issue),
    .lane_a    (lane_a),
    .lane_b    (lane_b),
    .lane_k    (lane_k),
    .gain      (gain)
  );

  lirg_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_ok   (issue_ok),
    .lane_res   (lane_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hdl/lirg_checker.sv */
// Port-level checker for the resampler and its binding to the top level.
`include "linear_interp_resampler_gain_macros.svh"

module lirg_checker #(
  parameter int CHANNELS = lirg_pkg::CHANNELS_DEF
) (
  input logic                                          clk,
  input logic                                          rst_n,
  input logic                                          in_tvalid,
  input logic                                          in_tready,
  input logic                                          out_tvalid,
  input logic                                          out_tready,
  input logic [((CHANNELS*lirg_pkg::OUT_W+7)/8)*8-1:0] out_tdata,
  input logic                                          out_tlast
);

  // A stalled result must not change under the consumer.
  `LIRG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // A frame is worked on before the next request is taken.
  `LIRG_ASSERT(a_in_busy, in_tvalid && in_tready |=> !in_tready, "frame taken while busy")

  // Reset empties the queue and leaves the block ready for a frame.
  `LIRG_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result shown after reset")
  `LIRG_ASSERT_RST(a_rst_ready, !rst_n |=> in_tready, "not ready after reset")

endmodule

bind linear_interp_resampler_gain lirg_checker #(.CHANNELS(CHANNELS)) u_lirg_checker (.*);

/* tb/tb_linear_interp_resampler_gain.sv */
// Self-checking testbench for the stereo linear interpolation resampler with gain.
module tb_linear_interp_resampler_gain;
  import lirg_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint SAT_MAX = 134217727;
  localparam longint SAT_MIN = -134217728;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    last;
  } out_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*SAMPLE_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [((2*OUT_W+7)/8)*8-1:0] out_tdata;
  logic out_tlast;

  linear_interp_resampler_gain uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register mirror and resampler state, as the block should hold them.
  logic [STEP_W-1:0]  step_r  = 20'd65536;
  logic [COUNT_W-1:0] count_r = COUNT_RST;
  logic [GAIN_W-1:0]  gain_r  = GAIN_RST;
  logic signed [SAMPLE_W-1:0] held_l = '0;
  logic signed [SAMPLE_W-1:0] held_r = '0;
  logic have_held = 1'b0;
  logic [POS_W-1:0] rd_pos = '0;
  int done_cnt = 0;
  logic [FRAMES_W-1:0] frames_seen = '0;

  out_frame_t pending_outputs[$];
  bit idle_en = 1'b1;
  int frames_sent = 0;
  int blocks_sent = 0;
  int settings_applied = 0;
  int outputs_checked = 0;
  int mismatches = 0;

  always @(posedge clk) begin
    out_tready <= !idle_en || ($urandom_range(99) >= 30);
  end

  function automatic logic [OUT_W-1:0] scale_point(input int a, input int b,
                                                   input logic [FB-1:0] k);
    longint acc;
    acc = longint'(a) * (longint'(1) << FB) + longint'(b - a) * longint'(k);
    acc = acc * longint'(gain_r);
    acc = acc + (longint'(1) << (FB + 3));
    // Arithmetic shift gives the floor, so adding half first rounds half up.
    acc = acc >>> (FB + 4);
    if (acc > SAT_MAX) acc = SAT_MAX;
    if (acc < SAT_MIN) acc = SAT_MIN;
    return acc[OUT_W-1:0];
  endfunction

  task automatic emit_point(input int al, input int ar, input int bl, input int br,
                            input logic [FB-1:0] k, inout int n);
    out_frame_t o;
    if (n < MAX_OUT_DEF) begin
      o.left  = scale_point(al, bl, k);
      o.right = scale_point(ar, br, k);
      o.last  = (done_cnt + 1 == int'(count_r));
      pending_outputs.push_back(o);
      n++;
    end
    // Outputs beyond the per-frame limit are dropped but still move the position.
    rd_pos = rd_pos + POS_W'(step_r);
    done_cnt++;
  endtask

  task automatic resample_frame(input logic signed [SAMPLE_W-1:0] l,
                                input logic signed [SAMPLE_W-1:0] r, input logic closes);
    int n;
    out_frame_t o;
    n = 0;
    if (have_held)
      while (done_cnt < int'(count_r) && rd_pos[POS_W-1:FB] < frames_seen)
        emit_point(held_l, held_r, l, r, rd_pos[FB-1:0], n);
    if (closes) begin
      while (done_cnt < int'(count_r))
        emit_point(l, r, l, r, '0, n);
      if (n > 0) begin
        o = pending_outputs.pop_back();
        o.last = 1'b1;
        pending_outputs.push_back(o);
      end
      have_held = 1'b0;
      rd_pos = '0;
      done_cnt = 0;
      frames_seen = '0;
    end else begin
      held_l = l;
      held_r = r;
      have_held = 1'b1;
      if (frames_seen != '1) frames_seen++;
    end
  endtask

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Results are sampled on the falling edge, before the transfer completes on the rising edge.
  always @(negedge clk) begin : check_outputs
    out_frame_t want;
    logic signed [OUT_W-1:0] got_l;
    logic signed [OUT_W-1:0] got_r;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got_l = out_tdata[OUT_W-1:0];
      got_r = out_tdata[2*OUT_W-1:OUT_W];
      if (pending_outputs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output, expected none, actual %0d %0d last %0b",
                 $time, got_l, got_r, out_tlast);
      end else begin
        want = pending_outputs.pop_front();
        outputs_checked++;
        if (got_l !== want.left) report_mismatch("out_left", want.left, got_l);
        if (got_r !== want.right) report_mismatch("out_right", want.right, got_r);
        if (out_tlast !== want.last) report_mismatch("out_last", want.last, out_tlast);
      end
    end
  end

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r, input logic closes);
    logic ready_seen;
    while (idle_en && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    in_tlast  <= closes;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = (in_tready === 1'b1);
      @(posedge clk);
    end
    resample_frame(l, r, closes);
    frames_sent++;
    if (closes) blocks_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++)
      send_frame(rand_sample(), rand_sample(), i == len - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_STEP:  step_r  = val[STEP_W-1:0];
      CFG_COUNT: count_r = val[COUNT_W-1:0];
      CFG_GAIN:  gain_r  = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [STEP_W-1:0] step, input logic [COUNT_W-1:0] count,
                                input logic [GAIN_W-1:0] g);
    write_reg(CFG_STEP, step);
    write_reg(CFG_COUNT, CFG_W'(count));
    write_reg(CFG_GAIN, CFG_W'(g));
    settings_applied++;
  endtask

  // Waits for every result, then leaves time for work that yields no result.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_frame(16'sh7FFF, -16'sh8000, 1'b0);
    send_frame(-16'sh8000, 16'sh7FFF, 1'b0);
    send_frame(16'sh0000, -16'sh0001, 1'b1);
    settle();
  endtask

  task automatic test_single_frame_block();
    apply_settings(20'd65536, 16'd3, GAIN_RST);
    send_frame(16'sh1234, -16'sh4321, 1'b1);
    settle();
  endtask

  task automatic test_gain_extremes();
    apply_settings(20'd32768, 16'd5, 16'd0);
    send_block(3);
    settle();
    apply_settings(20'd32768, 16'd5, 16'hFFFF);
    send_frame(-16'sh8000, 16'sh7FFF, 1'b0);
    send_frame(16'sh7FFF, -16'sh8000, 1'b0);
    send_frame(-16'sh8000, -16'sh8000, 1'b0);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
    settle();
  endtask

  task automatic test_unmapped_index();
    apply_settings(20'd65536, 16'd2, GAIN_RST);
    write_reg(CFG_UNMAPPED, CFG_W'($urandom));
    send_block(2);
    settle();
  endtask

  task automatic test_count_reached();
    apply_settings(20'd65536, 16'd2, 16'd2048);
    send_block(5);
    settle();
  endtask

  task automatic test_step_extremes();
    // Eight outputs fall due per frame, so the closing tail is dropped entirely.
    apply_settings(20'd8192, 16'd40, GAIN_RST);
    send_block(3);
    settle();
    apply_settings(20'hFFFFF, 16'd3, GAIN_RST);
    send_block(4);
    settle();
  endtask

  task automatic test_long_block();
    // Half-frame steps over a long block at full rate on both sides; the closing
    // frame brings the count up exactly from its own tail.
    idle_en = 1'b0;
    apply_settings(20'd32768, 16'd64, 16'd3000);
    for (int i = 0; i < 31; i++)
      send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b1);
    settle();
    idle_en = 1'b1;
  endtask

  function automatic int rand_block_len();
    case ($urandom_range(9))
      0: return 1;
      1, 2: return $urandom_range(24, 9);
      default: return $urandom_range(8, 2);
    endcase
  endfunction

  task automatic test_random_blocks();
    int start;
    int first_len;
    int sent;
    longint nominal;
    logic [STEP_W-1:0] step;
    logic [COUNT_W-1:0] count;
    logic [GAIN_W-1:0] g;
    start = frames_sent;
    while (frames_sent - start < 400) begin
      sent = frames_sent - start;
      // A stretch in the middle runs with both sides at full rate.
      idle_en = !(sent >= 150 && sent < 260);
      case ($urandom_range(19))
        0, 1, 2: count = 16'd2;
        3, 4:    count = 16'hFFFF;
        5, 6, 7: count = COUNT_W'($urandom_range(200, 13));
        default: count = COUNT_W'($urandom_range(12, 2));
      endcase
      first_len = rand_block_len();
      case ($urandom_range(19))
        0, 1, 2: step = 20'd8192;
        3, 4, 5: step = 20'hFFFFF;
        6, 7, 8, 9, 10: begin
          nominal = (longint'(first_len - 1) << FB) / longint'(count - 1);
          if (nominal < 8192) nominal = 8192;
          if (nominal > 1048575) nominal = 1048575;
          step = nominal[STEP_W-1:0];
        end
        default: step = STEP_W'($urandom_range(1048575, 8192));
      endcase
      case ($urandom_range(9))
        0, 1: g = 16'd0;
        2, 3: g = 16'hFFFF;
        4, 5: g = GAIN_RST;
        default: g = GAIN_W'($urandom);
      endcase
      apply_settings(step, count, g);
      send_block(first_len);
      repeat ($urandom_range(3)) send_block(rand_block_len());
      settle();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_single_frame_block();
    test_gain_extremes();
    test_unmapped_index();
    test_count_reached();
    test_step_extremes();
    test_long_block();
    test_random_blocks();
    $display("Run covered %0d frames in %0d blocks under %0d register settings.",
             frames_sent, blocks_sent, settings_applied);
    $display("%0d outputs checked, %0d mismatches.", outputs_checked, mismatches);
    if (mismatches == 0)
      $display("linear_interp_resampler_gain test passed");
    else
      $display("linear_interp_resampler_gain test failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("%0t: timed out with %0d outputs outstanding", $time, pending_outputs.size());
    $display("linear_interp_resampler_gain test failed");
    $finish;
  end

endmodule

/* linear_interp_resampler_gain.f */
+incdir+hdl
hdl/lirg_pkg.sv
hdl/lirg_lane.sv
hdl/lirg_ctrl.sv
hdl/lirg_merge.sv
hdl/linear_interp_resampler_gain.sv
hdl/lirg_checker.sv
tb/tb_linear_interp_resampler_gain.sv
